[rtl/tsm_pkg.sv]
// -----------------------------------------------------------------------------
// tsm_pkg
// Shared sizes, codes and interface types of the trie signature matcher.
// -----------------------------------------------------------------------------
package tsm_pkg;

   localparam int MAX_NODES = 256;
   localparam int MAX_TEXT  = 64;

   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int NODE_CW = $clog2(MAX_NODES + 1);
   localparam int KEY_W   = NODE_AW + 8;
   localparam int TEXT_AW = $clog2(MAX_TEXT);
   localparam int TEXT_CW = $clog2(MAX_TEXT + 1);

   // request kinds
   localparam logic [1:0] KIND_PATTERN = 2'd0;
   localparam logic [1:0] KIND_TEXT    = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;

   // result kinds
   localparam logic [1:0] RES_SEARCH  = 2'd0;
   localparam logic [1:0] RES_PATTERN = 2'd1;
   localparam logic [1:0] RES_CLEAR   = 2'd2;

   typedef struct packed {
      logic               en;
      logic [NODE_AW-1:0] addr;
      logic [KEY_W-1:0]   key;
   } tsm_edge_wr_type;

   typedef struct packed {
      logic               done;
      logic               found;
      logic [NODE_AW-1:0] node;
   } tsm_search_rsp_type;

endpackage

[rtl/tsm_ram.sv]
// -----------------------------------------------------------------------------
// tsm_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module tsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/tsm_child_search.sv]
// -----------------------------------------------------------------------------
// tsm_child_search
// Holds the edge table and scans it, one entry a cycle, for a parent/byte key.
// -----------------------------------------------------------------------------
module tsm_child_search import tsm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [NODE_AW-1:0] parent,
   input  logic [7:0]         key_byte,
   input  logic [NODE_CW-1:0] node_count,
   input  tsm_edge_wr_type    edge_wr,
   output tsm_search_rsp_type rsp
);

   logic               active_ff, active_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [NODE_AW-1:0] pend_idx_ff, pend_idx_in;
   logic [NODE_CW-1:0] next_ff, next_in;
   tsm_search_rsp_type rsp_ff, rsp_in;
   logic               rd_en;
   logic [NODE_AW-1:0] rd_addr;
   logic [KEY_W-1:0]   rd_data;

   tsm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_NODES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr.en),
      .wr_addr (edge_wr.addr),
      .wr_data (edge_wr.key),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      active_in   = active_ff;
      key_in      = key_ff;
      pend_idx_in = pend_idx_ff;
      next_in     = next_ff;
      rsp_in      = '0;
      rd_en       = 1'b0;
      rd_addr     = next_ff[NODE_AW-1:0];
      if (go) begin
         key_in = {parent, key_byte};
         if (node_count > NODE_CW'(1)) begin
            rd_en       = 1'b1;
            rd_addr     = NODE_AW'(1);
            pend_idx_in = NODE_AW'(1);
            next_in     = NODE_CW'(2);
            active_in   = 1'b1;
         end else begin
            rsp_in.done = 1'b1;
         end
      end else if (active_ff) begin
         if (rd_data == key_ff) begin
            rsp_in.done  = 1'b1;
            rsp_in.found = 1'b1;
            rsp_in.node  = pend_idx_ff;
            active_in    = 1'b0;
         end else if (next_ff < node_count) begin
            // advance to the next stored edge
            rd_en       = 1'b1;
            pend_idx_in = next_ff[NODE_AW-1:0];
            next_in     = next_ff + NODE_CW'(1);
         end else begin
            rsp_in.done = 1'b1;
            active_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rsp_ff    <= '0;
      end else begin
         active_ff <= active_in;
         rsp_ff    <= rsp_in;
      end
      key_ff      <= key_in;
      pend_idx_ff <= pend_idx_in;
      next_ff     <= next_in;
   end

   assign rsp = rsp_ff;

endmodule

[rtl/trie_signature_matcher.sv]
// -----------------------------------------------------------------------------
// trie_signature_matcher
// Byte trie of typed signatures with prefix and full-text search.
// -----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------
//  request  | req_kind, req_byte_value,               | start & !busy
//           | req_pattern_type, req_last              |
//  result   | rsp_result_kind, rsp_match_type,        | rsp_valid, one cycle,
//           | rsp_overflow                            | cannot be held off
//  csr      | csr_search_mode                         | csr_valid & csr_ready
//
// A request is handled one at a time. A text byte that is not last is stored
// and the block returns to idle. A pattern byte scans the edge table one entry
// a cycle through the read port of its RAM. A search scans the edge table for
// each text byte walked and, unless the walk fails at the root, reads the tag of
// the node reached; a full search restarts at each later start position that
// leaves two text bytes, so the bytes walked grow with the square of the length.
// Reset is synchronous and needs no clearing pass: node tags are written when
// their node is allocated, and the node count bounds every edge scan.
// -----------------------------------------------------------------------------
module trie_signature_matcher import tsm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_pattern_type,
   input  logic       req_last,
   output logic       rsp_valid,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_match_type,
   output logic       rsp_overflow,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_search_mode
);

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_PAT_WAIT, S_TXT_RD, S_SRCH_GO, S_SRCH_WAIT,
      S_TAG_RD, S_TAG_USE
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         kind_ff;
   logic [7:0]         byte_ff, ptype_ff;
   logic               last_ff;
   logic               search_mode_ff;
   logic [NODE_CW-1:0] node_count_ff, node_count_in;
   logic [NODE_AW-1:0] load_node_ff, load_node_in;
   logic               load_broken_ff, load_broken_in;
   logic [TEXT_CW-1:0] text_count_ff, text_count_in;
   logic               text_broken_ff, text_broken_in;
   logic [TEXT_CW-1:0] start_pos_ff, start_pos_in;
   logic [TEXT_CW-1:0] idx_ff, idx_in;
   logic [NODE_AW-1:0] cur_ff, cur_in;
   logic               full_ff, full_in;
   logic               at_end_ff, at_end_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_match_ff, rsp_match_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               accept;
   logic               srch_go;
   logic [NODE_AW-1:0] srch_parent;
   logic [7:0]         srch_byte;
   tsm_search_rsp_type srch_rsp;
   tsm_edge_wr_type    edge_wr;

   logic               tag_wr_en;
   logic [NODE_AW-1:0] tag_wr_addr;
   logic [7:0]         tag_wr_data;
   logic               tag_rd_en;
   logic [7:0]         tag_rd_data;

   logic               text_wr_en;
   logic               text_rd_en;
   logic [7:0]         text_rd_data;

   // combinational helpers
   logic               do_rsp;
   logic               next_start;
   logic               fin_pattern;
   logic               pat_broken;
   logic [TEXT_CW:0]   s1;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   tsm_child_search u_child_search (
      .clock      (clock),
      .reset      (reset),
      .go         (srch_go),
      .parent     (srch_parent),
      .key_byte   (srch_byte),
      .node_count (node_count_ff),
      .edge_wr    (edge_wr),
      .rsp        (srch_rsp)
   );

   tsm_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (tag_rd_en),
      .rd_addr (cur_ff),
      .rd_data (tag_rd_data)
   );

   tsm_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text_ram (
      .clock   (clock),
      .wr_en   (text_wr_en),
      .wr_addr (text_count_ff[TEXT_AW-1:0]),
      .wr_data (byte_ff),
      .rd_en   (text_rd_en),
      .rd_addr (idx_ff[TEXT_AW-1:0]),
      .rd_data (text_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      node_count_in  = node_count_ff;
      load_node_in   = load_node_ff;
      load_broken_in = load_broken_ff;
      text_count_in  = text_count_ff;
      text_broken_in = text_broken_ff;
      start_pos_in   = start_pos_ff;
      idx_in         = idx_ff;
      cur_in         = cur_ff;
      full_in        = full_ff;
      at_end_in      = at_end_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_match_in   = rsp_match_ff;
      rsp_ovf_in     = rsp_ovf_ff;

      do_rsp      = 1'b0;
      next_start  = 1'b0;
      fin_pattern = 1'b0;
      pat_broken  = 1'b0;
      s1          = '0;

      srch_go     = 1'b0;
      srch_parent = cur_ff;
      srch_byte   = text_rd_data;
      edge_wr     = '0;
      tag_wr_en   = 1'b0;
      tag_wr_addr = load_node_ff;
      tag_wr_data = ptype_ff;
      tag_rd_en   = 1'b0;
      text_wr_en  = 1'b0;
      text_rd_en  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            unique case (kind_ff)
               KIND_PATTERN: begin
                  if (load_broken_ff) begin
                     fin_pattern = 1'b1;
                     pat_broken  = 1'b1;
                  end else begin
                     srch_go     = 1'b1;
                     srch_parent = load_node_ff;
                     srch_byte   = byte_ff;
                     state_in    = S_PAT_WAIT;
                  end
               end
               KIND_TEXT: begin
                  if (text_count_ff < TEXT_CW'(MAX_TEXT)) begin
                     text_wr_en    = 1'b1;
                     text_count_in = text_count_ff + TEXT_CW'(1);
                  end else begin
                     text_broken_in = 1'b1;
                  end
                  if (!last_ff) begin
                     state_in = S_IDLE;
                  end else if (text_count_in == '0 ||
                               (search_mode_ff && text_count_in < TEXT_CW'(2))) begin
                     do_rsp       = 1'b1;
                     rsp_kind_in  = RES_SEARCH;
                     rsp_match_in = 8'd0;
                  end else begin
                     // walk from the root at text start
                     full_in      = search_mode_ff;
                     start_pos_in = '0;
                     idx_in       = '0;
                     cur_in       = '0;
                     state_in     = S_TXT_RD;
                  end
               end
               KIND_CLEAR: begin
                  node_count_in  = NODE_CW'(1);
                  load_node_in   = '0;
                  load_broken_in = 1'b0;
                  do_rsp         = 1'b1;
                  rsp_kind_in    = RES_CLEAR;
                  rsp_match_in   = 8'd0;
                  rsp_ovf_in     = 1'b0;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_PAT_WAIT: begin
            if (srch_rsp.done) begin
               fin_pattern = 1'b1;
               if (srch_rsp.found) begin
                  load_node_in = srch_rsp.node;
                  tag_wr_en    = last_ff;
                  tag_wr_addr  = srch_rsp.node;
               end else if (node_count_ff < NODE_CW'(MAX_NODES)) begin
                  // allocate a new node; its tag starts empty unless last
                  edge_wr.en    = 1'b1;
                  edge_wr.addr  = node_count_ff[NODE_AW-1:0];
                  edge_wr.key   = {load_node_ff, byte_ff};
                  tag_wr_en     = 1'b1;
                  tag_wr_addr   = node_count_ff[NODE_AW-1:0];
                  tag_wr_data   = last_ff ? ptype_ff : 8'd0;
                  load_node_in  = node_count_ff[NODE_AW-1:0];
                  node_count_in = node_count_ff + NODE_CW'(1);
               end else begin
                  pat_broken = 1'b1;
               end
            end
         end

         S_TXT_RD: begin
            text_rd_en = 1'b1;
            state_in   = S_SRCH_GO;
         end

         S_SRCH_GO: begin
            srch_go  = 1'b1;
            state_in = S_SRCH_WAIT;
         end

         S_SRCH_WAIT: begin
            if (srch_rsp.done) begin
               if (srch_rsp.found) begin
                  cur_in = srch_rsp.node;
                  idx_in = idx_ff + TEXT_CW'(1);
                  if (idx_in == text_count_ff) begin
                     at_end_in = 1'b1;
                     state_in  = S_TAG_RD;
                  end else begin
                     state_in = S_TXT_RD;
                  end
               end else if (cur_ff == '0) begin
                  if (full_ff) begin
                     next_start = 1'b1;
                  end else begin
                     do_rsp       = 1'b1;
                     rsp_kind_in  = RES_SEARCH;
                     rsp_match_in = 8'd0;
                  end
               end else begin
                  at_end_in = 1'b0;
                  state_in  = S_TAG_RD;
               end
            end
         end

         S_TAG_RD: begin
            tag_rd_en = 1'b1;
            state_in  = S_TAG_USE;
         end

         S_TAG_USE: begin
            if (at_end_ff || !full_ff || tag_rd_data != 8'd0) begin
               do_rsp       = 1'b1;
               rsp_kind_in  = RES_SEARCH;
               rsp_match_in = tag_rd_data;
            end else begin
               next_start = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // retry the walk from the next start position, if one is left
      if (next_start) begin
         s1 = {1'b0, start_pos_ff} + (TEXT_CW + 1)'(1);
         if (s1 + (TEXT_CW + 1)'(1) < {1'b0, text_count_ff}) begin
            start_pos_in = s1[TEXT_CW-1:0];
            idx_in       = s1[TEXT_CW-1:0];
            cur_in       = '0;
            state_in     = S_TXT_RD;
         end else begin
            do_rsp       = 1'b1;
            rsp_kind_in  = RES_SEARCH;
            rsp_match_in = 8'd0;
         end
      end

      if (fin_pattern) begin
         if (pat_broken) begin
            load_broken_in = 1'b1;
         end
         if (last_ff) begin
            do_rsp         = 1'b1;
            rsp_kind_in    = RES_PATTERN;
            rsp_match_in   = 8'd0;
            rsp_ovf_in     = load_broken_in;
            load_node_in   = '0;
            load_broken_in = 1'b0;
         end else begin
            state_in = S_IDLE;
         end
      end

      if (do_rsp) begin
         rsp_valid_in = 1'b1;
         state_in     = S_IDLE;
         if (rsp_kind_in == RES_SEARCH) begin
            rsp_ovf_in     = text_broken_in;
            text_count_in  = '0;
            text_broken_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         search_mode_ff <= 1'b0;
         node_count_ff  <= NODE_CW'(1);
         load_node_ff   <= '0;
         load_broken_ff <= 1'b0;
         text_count_ff  <= '0;
         text_broken_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         node_count_ff  <= node_count_in;
         load_node_ff   <= load_node_in;
         load_broken_ff <= load_broken_in;
         text_count_ff  <= text_count_in;
         text_broken_ff <= text_broken_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            search_mode_ff <= csr_search_mode;
         end
      end
      // hold the request fields for the whole operation
      if (accept) begin
         kind_ff  <= req_kind;
         byte_ff  <= req_byte_value;
         ptype_ff <= req_pattern_type;
         last_ff  <= req_last;
      end
      start_pos_ff <= start_pos_in;
      idx_ff       <= idx_in;
      cur_ff       <= cur_in;
      full_ff      <= full_in;
      at_end_ff    <= at_end_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_match_type  = rsp_match_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   // a result appears only as a request finishes
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result without a request in progress");

   // node count stays within the store and never loses the root
   a_node_count: assert property (@(posedge clock) disable iff (reset)
      node_count_ff != '0 && node_count_ff <= NODE_CW'(MAX_NODES))
      else $error("node count out of range");

   a_text_count: assert property (@(posedge clock) disable iff (reset)
      text_count_ff <= TEXT_CW'(MAX_TEXT))
      else $error("text count out of range");

   // an accepted request always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not start");

endmodule
